@@ sv/ntc_pkg.sv @@
// Package with shared constants, codes and control structures of the thermistor unit.
package ntc_pkg;

	localparam int NUM_CHANNELS     = 2;
	localparam int SAMPLE_BITS      = 12;
	localparam int AVERAGE_SHIFT    = 9;
	localparam int AVERAGE_FRACTION = 16;

	localparam int CH_W   = 4;
	localparam int SMP_W  = 12;
	localparam int ACC_W  = 32;
	localparam int CHI_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SUM_W  = ACC_W + AVERAGE_SHIFT + 1;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 6;

	localparam logic [SMP_W-1:0] CODE_FULL = SMP_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [ACC_W-1:0] EMPTY_MARK = '1;

	localparam logic [33:0] KELVIN_Q24  = 34'd4582696550;
	localparam logic [23:0] LN2_Q24     = 24'd11629080;
	localparam logic [19:0] MICRO_SCALE = 20'd1000000;
	localparam logic signed [63:0] LIMIT_Q24 = 64'sd5033164800;
	localparam logic signed [9:0]  LIMIT_DEG = 10'sd300;

	localparam int LOG_STEPS = 24;
	localparam int DIV_STEPS = 64;

	localparam logic [IDX_W-1:0] REG_BETA = 3'd0;
	localparam logic [IDX_W-1:0] REG_REF  = 3'd1;
	localparam logic [IDX_W-1:0] REG_NOM  = 3'd2;
	localparam logic [IDX_W-1:0] REG_T0   = 3'd3;
	localparam logic [IDX_W-1:0] REG_TOP  = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD_CH = 2'd1;
	localparam logic [1:0] ST_RAIL   = 2'd2;

	localparam logic [1:0] SEL_A    = 2'd0;
	localparam logic [1:0] SEL_B    = 2'd1;
	localparam logic [1:0] SEL_TERM = 2'd0;
	localparam logic [1:0] SEL_INV0 = 2'd1;
	localparam logic [1:0] SEL_TK   = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_AVG, OP_PROD, OP_LOG_INIT, OP_LOG_STEP, OP_LOG_SAVE,
		OP_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_SAVE, OP_INV, OP_CEL, OP_FIN
	} op_t;

	typedef enum logic [1:0] {RES_BAD, RES_RAIL, RES_NORM} res_kind_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;
		logic       res_wr;
		res_kind_t  kind;
	} cmd_t;

	typedef struct packed {
		logic bad_ch;
		logic rail;
		logic hot;
	} stat_t;

endpackage

@@ sv/ntc_ctrl.sv @@
// Sequencer of the thermistor unit: steps the datapath through one conversion.
module ntc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  ntc_pkg::stat_t stat,
	output ntc_pkg::cmd_t  cmd
);
	import ntc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'b0000000000000001,
		S_CHK   = 16'b0000000000000010,
		S_RAIL  = 16'b0000000000000100,
		S_LINIT = 16'b0000000000001000,
		S_LSTEP = 16'b0000000000010000,
		S_LSAVE = 16'b0000000000100000,
		S_MUL   = 16'b0000000001000000,
		S_DINIT = 16'b0000000010000000,
		S_DSTEP = 16'b0000000100000000,
		S_DSAVE = 16'b0000001000000000,
		S_INV   = 16'b0000010000000000,
		S_HOT   = 16'b0000100000000000,
		S_CEL   = 16'b0001000000000000,
		S_FIN   = 16'b0010000000000000,
		S_WAIT  = 16'b0100000000000000,
		S_SPARE = 16'b1000000000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       sel_q, sel_d;
	res_kind_t        kind_q, kind_d;
	logic             valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = valid_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		sel_d      = sel_q;
		kind_d     = kind_q;
		cmd.op     = OP_NONE;
		cmd.sel    = sel_q;
		cmd.res_wr = 1'b0;
		cmd.kind   = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.bad_ch) begin
					kind_d  = RES_BAD;
					state_d = S_WAIT;
				end else begin
					cmd.op  = OP_AVG;
					state_d = S_RAIL;
				end
			end
			S_RAIL: begin
				cmd.op = OP_PROD;
				if (stat.rail) begin
					kind_d  = RES_RAIL;
					state_d = S_WAIT;
				end else begin
					sel_d   = SEL_A;
					state_d = S_LINIT;
				end
			end
			S_LINIT: begin
				cmd.op  = OP_LOG_INIT;
				cnt_d   = '0;
				state_d = S_LSTEP;
			end
			S_LSTEP: begin
				cmd.op = OP_LOG_STEP;
				cnt_d  = CNT_W'(cnt_q + 1'b1);
				if (cnt_q == CNT_W'(LOG_STEPS - 1)) begin
					state_d = S_LSAVE;
				end
			end
			S_LSAVE: begin
				cmd.op = OP_LOG_SAVE;
				if (sel_q == SEL_A) begin
					sel_d   = SEL_B;
					state_d = S_LINIT;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				sel_d   = SEL_TERM;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = CNT_W'(cnt_q + 1'b1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_DSAVE;
				end
			end
			S_DSAVE: begin
				cmd.op = OP_DIV_SAVE;
				priority if (sel_q == SEL_TERM) begin
					sel_d   = SEL_INV0;
					state_d = S_DINIT;
				end else if (sel_q == SEL_INV0) begin
					state_d = S_INV;
				end else begin
					state_d = S_CEL;
				end
			end
			S_INV: begin
				cmd.op  = OP_INV;
				state_d = S_HOT;
			end
			S_HOT: begin
				if (stat.hot) begin
					kind_d  = RES_NORM;
					state_d = S_WAIT;
				end else begin
					sel_d   = SEL_TK;
					state_d = S_DINIT;
				end
			end
			S_CEL: begin
				cmd.op  = OP_CEL;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				kind_d  = RES_NORM;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!valid_q || m_tready) begin
					cmd.res_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= SEL_A;
			kind_q  <= RES_NORM;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			kind_q  <= kind_d;
			if (cmd.res_wr) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_wr |-> (!valid_q || m_tready))
		else $error("result written over a pending transfer");

	// After an input transfer the unit is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// A written result is offered in the next cycle.
	a_offer_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_wr |=> m_tvalid)
		else $error("written result not offered");

endmodule

@@ sv/ntc_dp.sv @@
// Datapath of the thermistor unit: averages, logarithm, shared divider and result register.
module ntc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ntc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0]   cfg_data,
	input  logic [ntc_pkg::CH_W-1:0]    in_channel,
	input  logic [ntc_pkg::SMP_W-1:0]   in_sample,
	input  ntc_pkg::cmd_t               cmd,
	output ntc_pkg::stat_t              stat,
	output logic signed [9:0]           whole_degrees,
	output logic signed [20:0]          micro_degrees,
	output logic [1:0]                  status
);
	import ntc_pkg::*;

	logic [14:0]        beta_q;
	logic [15:0]        rref_q, rnom_q;
	logic signed [7:0]  nc_q;
	logic               top_q;

	logic [CH_W-1:0]    ch_q;
	logic [SMP_W-1:0]   smp_q;
	logic [ACC_W-1:0]   avg_q [NUM_CHANNELS];
	logic [SMP_W-1:0]   code_q;
	logic [31:0]        a_q, b_q;
	logic [4:0]         e_q;
	logic [31:0]        m_q;
	logic [23:0]        frac_q;
	logic [28:0]        la_q, lb_q;
	logic               neg_d_q;
	logic [42:0]        prod_q;
	logic [63:0]        dvd_q, dvs_q, rem_q, quo_q;
	logic [42:0]        term_q;
	logic [31:0]        inv0_q;
	logic [43:0]        inv_q;
	logic [62:0]        tk_q;
	logic               hot_q, cold_q, neg_q;
	logic [32:0]        cmag_q;
	logic [19:0]        micro_q;

	logic [CHI_W-1:0]   idx;
	logic [ACC_W-1:0]   avg_old, scaled, avg_new;
	logic [SUM_W-1:0]   sum;
	logic [14:0]        beta_e;
	logic [15:0]        rref_e, rnom_e;
	logic [SMP_W-1:0]   num, den;
	logic [31:0]        lx;
	logic [4:0]         le;
	logic [63:0]        sq;
	logic [32:0]        sq_t;
	logic signed [29:0] d;
	logic [28:0]        mag;
	logic [52:0]        prod;
	logic [33:0]        t0;
	logic [64:0]        sh;
	logic               qbit;
	logic signed [44:0] inv_n;
	logic signed [63:0] c_n;
	logic [63:0]        cabs;
	logic [43:0]        mp;
	logic signed [9:0]  whole_n;

	assign idx     = ch_q[CHI_W-1:0];
	assign avg_old = avg_q[idx];
	assign scaled  = ACC_W'(smp_q & CODE_FULL) << AVERAGE_FRACTION;
	assign sum     = (SUM_W'(avg_old) << AVERAGE_SHIFT) - SUM_W'(avg_old) + SUM_W'(scaled);
	assign avg_new = (avg_old == EMPTY_MARK) ? scaled : ACC_W'(sum >> AVERAGE_SHIFT);

	assign beta_e = (beta_q == '0) ? 15'd1 : beta_q;
	assign rref_e = (rref_q == '0) ? 16'd1 : rref_q;
	assign rnom_e = (rnom_q == '0) ? 16'd1 : rnom_q;
	assign num    = top_q ? (CODE_FULL - code_q) : code_q;
	assign den    = top_q ? code_q : (CODE_FULL - code_q);

	always_comb begin
		lx = (cmd.sel == SEL_A) ? a_q : b_q;
		if (lx == '0) begin
			lx = 32'd1;
		end
		le = '0;
		for (int i = 0; i < 32; i++) begin
			if (lx[i]) begin
				le = 5'(i);
			end
		end
	end

	assign sq   = 64'(m_q) * 64'(m_q);
	assign sq_t = sq[63:31];

	assign d    = $signed({1'b0, la_q}) - $signed({1'b0, lb_q});
	assign mag  = d[29] ? 29'(-d) : d[28:0];
	assign prod = 53'(mag) * 53'(LN2_Q24);
	assign t0   = {{2{nc_q[7]}}, nc_q, 24'd0} + KELVIN_Q24;

	assign sh   = {rem_q, dvd_q[63]};
	assign qbit = (sh >= {1'b0, dvs_q});

	assign inv_n = neg_d_q ? ($signed({13'd0, inv0_q}) - $signed({2'd0, term_q}))
	                       : ($signed({13'd0, inv0_q}) + $signed({2'd0, term_q}));
	assign c_n   = $signed({1'b0, tk_q}) - $signed(64'(KELVIN_Q24));
	assign cabs  = c_n[63] ? 64'(-c_n) : 64'(c_n);
	assign mp    = 44'(cmag_q[23:0]) * 44'(MICRO_SCALE);

	assign stat.bad_ch = ({1'b0, ch_q} >= (CH_W + 1)'(NUM_CHANNELS));
	assign stat.rail   = (code_q == '0) || (code_q == CODE_FULL);
	assign stat.hot    = hot_q;

	assign whole_n = neg_q ? -$signed({1'b0, cmag_q[32:24]}) : $signed({1'b0, cmag_q[32:24]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= 15'd3380;
			rref_q <= 16'd10000;
			rnom_q <= 16'd10000;
			nc_q   <= 8'sd25;
			top_q  <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				avg_q[i] <= EMPTY_MARK;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BETA: beta_q <= cfg_data[14:0];
					REG_REF:  rref_q <= cfg_data;
					REG_NOM:  rnom_q <= cfg_data;
					REG_T0:   nc_q   <= $signed(cfg_data[7:0]);
					REG_TOP:  top_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_AVG) begin
				avg_q[idx] <= avg_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				ch_q  <= in_channel;
				smp_q <= in_sample;
			end
			OP_AVG: begin
				code_q <= SMP_W'(avg_new >> AVERAGE_FRACTION) & CODE_FULL;
			end
			OP_PROD: begin
				a_q <= 32'(rref_e) * 32'(num);
				b_q <= 32'(rnom_e) * 32'(den);
			end
			OP_LOG_INIT: begin
				e_q    <= le;
				m_q    <= lx << (5'd31 - le);
				frac_q <= '0;
			end
			OP_LOG_STEP: begin
				if (sq_t[32]) begin
					m_q    <= sq_t[32:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					m_q    <= sq_t[31:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			OP_LOG_SAVE: begin
				if (cmd.sel == SEL_A) begin
					la_q <= {e_q, frac_q};
				end else begin
					lb_q <= {e_q, frac_q};
				end
			end
			OP_MUL: begin
				neg_d_q <= d[29];
				prod_q  <= prod[52:10];
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= '0;
				priority if (cmd.sel == SEL_TERM) begin
					dvd_q <= 64'(prod_q);
					dvs_q <= 64'(beta_e);
				end else if (cmd.sel == SEL_INV0) begin
					dvd_q <= 64'd1 << 62;
					dvs_q <= 64'(t0);
				end else begin
					dvd_q <= 64'd1 << 62;
					dvs_q <= 64'(inv_q);
				end
			end
			OP_DIV_STEP: begin
				rem_q <= qbit ? 64'(sh - {1'b0, dvs_q}) : sh[63:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], qbit};
			end
			OP_DIV_SAVE: begin
				priority if (cmd.sel == SEL_TERM) begin
					term_q <= quo_q[42:0];
				end else if (cmd.sel == SEL_INV0) begin
					inv0_q <= quo_q[31:0];
				end else begin
					tk_q <= quo_q[62:0];
				end
			end
			OP_INV: begin
				inv_q  <= inv_n[43:0];
				hot_q  <= inv_n[44] || (inv_n == '0);
				cold_q <= 1'b0;
			end
			OP_CEL: begin
				hot_q  <= (c_n >= LIMIT_Q24);
				cold_q <= (c_n <= -LIMIT_Q24);
				neg_q  <= c_n[63];
				cmag_q <= cabs[32:0];
			end
			OP_FIN: begin
				micro_q <= mp[43:24];
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase

		if (cmd.res_wr) begin
			unique case (cmd.kind)
				RES_BAD: begin
					whole_degrees <= '0;
					micro_degrees <= '0;
					status        <= ST_BAD_CH;
				end
				RES_RAIL: begin
					whole_degrees <= '0;
					micro_degrees <= '0;
					status        <= ST_RAIL;
				end
				default: begin
					status <= ST_OK;
					priority if (hot_q) begin
						whole_degrees <= LIMIT_DEG;
						micro_degrees <= '0;
					end else if (cold_q) begin
						whole_degrees <= -LIMIT_DEG;
						micro_degrees <= '0;
					end else begin
						whole_degrees <= whole_n;
						micro_degrees <= neg_q ? -$signed({1'b0, micro_q}) : $signed({1'b0, micro_q});
					end
				end
			endcase
		end
	end

endmodule

@@ sv/ntc_thermistor_temperature_unit.sv @@
// Top level of the NTC thermistor temperature unit with per-channel averaging.
//
//   Channel   Direction  Contents
//   s_axis    in         channel, sample
//   m_axis    out        whole_degrees, micro_degrees, status
//   cfg       in         beta, reference ohms, nominal ohms, nominal Celsius, orientation
//
// A good item runs two 24-round logarithms on one squaring multiplier and three 64-step
// divisions on one restoring divider; an item that saturates hot skips the third division.
// A bad channel and an averaged code at a rail finish early, before any logarithm.
// Reset clears the averages to empty and loads the register defaults.
// A finished result waits in the output register while the next item is taken.
module ntc_thermistor_temperature_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // channel[3:0], sample[15:4]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [39:0]               m_tdata,   // whole_degrees[9:0], micro_degrees[30:10], status[32:31]
	input  logic                      cfg_we,
	input  logic [ntc_pkg::IDX_W-1:0] cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0] cfg_data
);
	import ntc_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic signed [9:0]  whole_degrees;
	logic signed [20:0] micro_degrees;
	logic [1:0]         status;

	ntc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ntc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_channel    (s_tdata[3:0]),
		.in_sample     (s_tdata[15:4]),
		.cmd           (cmd),
		.stat          (stat),
		.whole_degrees (whole_degrees),
		.micro_degrees (micro_degrees),
		.status        (status)
	);

	assign m_tdata = {7'd0, status, micro_degrees, whole_degrees};

endmodule

@@ bench/ntc_temperature_checker.sv @@
// Checker that predicts and compares every result transfer of the thermistor unit.
module ntc_temperature_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [15:0]               s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [39:0]               m_tdata,
	input  logic                      cfg_we,
	input  logic [ntc_pkg::IDX_W-1:0] cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0] cfg_data,
	output int                        pending,
	output int                        errors
);
	import ntc_pkg::*;

	typedef struct packed {
		logic [9:0]  whole;
		logic [20:0] micro;
		logic [1:0]  status;
	} reading_t;

	localparam longint KELVIN = 64'sd4582696550;
	localparam longint LIMIT  = 64'sd300 * 64'sd16777216;
	localparam longint unsigned TWO_62 = 64'd1 << 62;

	logic [14:0]       beta_k;
	logic [15:0]       ref_ohms;
	logic [15:0]       nom_ohms;
	logic signed [7:0] nom_celsius;
	logic              therm_top;
	logic [31:0]       channel_avg [NUM_CHANNELS];
	reading_t          expected_readings [$];

	function automatic logic [31:0] log2_q24(logic [31:0] x);
		int          e;
		logic [63:0] m;
		logic [23:0] frac;
		if (x == 0)
			x = 1;
		e = 0;
		frac = '0;
		while (e < 31 && (x >> (e + 1)) != 0)
			e++;
		m = 64'(x) << (31 - e);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 31;
			frac = {frac[22:0], 1'b0};
			if (m >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (32'(e) << 24) | 32'(frac);
	endfunction

	task automatic predict_temperature(input logic [3:0] ch, input logic [11:0] smp);
		reading_t           r;
		logic [31:0]        scaled, beta, rref, rnom, num, den, la, lb;
		logic [11:0]        code;
		logic [63:0]        sum;
		longint             d, inv, c, t0;
		longint unsigned    mag, term, inv0, tk, cmag, frac;
		r = '0;
		scaled = 32'(smp) << AVERAGE_FRACTION;
		if (ch >= NUM_CHANNELS) begin
			r.status = ST_BAD_CH;
			expected_readings.push_back(r);
			return;
		end
		if (channel_avg[ch] == EMPTY_MARK)
			channel_avg[ch] = scaled;
		else begin
			sum = ((64'd1 << AVERAGE_SHIFT) - 1) * 64'(channel_avg[ch]) + 64'(scaled);
			channel_avg[ch] = 32'(sum >> AVERAGE_SHIFT);
		end
		code = 12'(channel_avg[ch] >> AVERAGE_FRACTION);
		if (code == 0 || code == CODE_FULL) begin
			r.status = ST_RAIL;
			expected_readings.push_back(r);
			return;
		end
		beta = beta_k != 0 ? 32'(beta_k) : 32'd1;
		rref = ref_ohms != 0 ? 32'(ref_ohms) : 32'd1;
		rnom = nom_ohms != 0 ? 32'(nom_ohms) : 32'd1;
		if (therm_top) begin
			num = 32'(CODE_FULL - code);
			den = 32'(code);
		end else begin
			num = 32'(code);
			den = 32'(CODE_FULL - code);
		end
		la = log2_q24(rref * num);
		lb = log2_q24(rnom * den);
		d = longint'(la) - longint'(lb);
		mag = d < 0 ? -d : d;
		term = (mag * 64'd11629080) / (64'(beta) * 64'd1024);
		t0 = longint'(nom_celsius) * 64'sd16777216 + KELVIN;
		inv0 = TWO_62 / longint'(t0);
		inv = longint'(inv0) + (d < 0 ? -longint'(term) : longint'(term));
		r.status = ST_OK;
		if (inv <= 0) begin
			r.whole = 10'd300;
		end else begin
			tk = TWO_62 / inv;
			c = longint'(tk) - KELVIN;
			if (c >= LIMIT)
				r.whole = 10'd300;
			else if (c <= -LIMIT)
				r.whole = -10'sd300;
			else begin
				cmag = c < 0 ? -c : c;
				frac = ((cmag & 64'hFF_FFFF) * 64'd1000000) >> 24;
				r.whole = c < 0 ? 10'(-longint'(cmag >> 24)) : 10'(cmag >> 24);
				r.micro = c < 0 ? 21'(-longint'(frac)) : 21'(frac);
			end
		end
		expected_readings.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	assign pending = expected_readings.size();

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		reading_t w;
		reading_t g;
		if (!arst_n) begin
			beta_k <= 15'd3380;
			ref_ohms <= 16'd10000;
			nom_ohms <= 16'd10000;
			nom_celsius <= 8'sd25;
			therm_top <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				channel_avg[i] = EMPTY_MARK;
			expected_readings.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				g.whole = m_tdata[9:0];
				g.micro = m_tdata[30:10];
				g.status = m_tdata[32:31];
				if (expected_readings.size() == 0)
					report_mismatch("unexpected result transfer", 1, 0);
				else begin
					w = expected_readings.pop_front();
					if (g.whole != w.whole)
						report_mismatch("whole_degrees", $signed(g.whole), $signed(w.whole));
					if (g.micro != w.micro)
						report_mismatch("micro_degrees", $signed(g.micro), $signed(w.micro));
					if (g.status != w.status)
						report_mismatch("status", g.status, w.status);
				end
			end
			if (s_tvalid && s_tready)
				predict_temperature(s_tdata[3:0], s_tdata[15:4]);
			if (cfg_we) begin
				case (cfg_index)
					REG_BETA: beta_k <= cfg_data[14:0];
					REG_REF:  ref_ohms <= cfg_data;
					REG_NOM:  nom_ohms <= cfg_data;
					REG_T0:   nom_celsius <= cfg_data[7:0];
					REG_TOP:  therm_top <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

@@ bench/tb_ntc_thermistor_temperature_unit.sv @@
// Testbench top that drives the thermistor unit and gives the final verdict.
module tb_ntc_thermistor_temperature_unit;
	import ntc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [39:0]        m_tdata;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = REG_BETA;
	logic [CFG_W-1:0]   cfg_data = '0;
	int                 pending;
	int                 errors;
	logic               steady = 1'b0;
	int                 stall_left = 0;

	ntc_thermistor_temperature_unit DUT (.*);

	ntc_temperature_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (steady || !arst_n)
			m_tready <= 1'b1;
		else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(7) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(4);
		end else
			m_tready <= 1'b1;
	end

	task automatic send_sample(input logic [3:0] ch, input logic [11:0] smp);
		int gap;
		gap = (!steady && $urandom_range(5) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {smp, ch};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_settings(input logic [14:0] beta, input logic [15:0] rref,
			input logic [15:0] rnom, input logic [7:0] t0, input logic top);
		cfg_we <= 1'b1;
		cfg_index <= REG_BETA; cfg_data <= 16'(beta); @(posedge clk);
		cfg_index <= REG_REF;  cfg_data <= rref;      @(posedge clk);
		cfg_index <= REG_NOM;  cfg_data <= rnom;      @(posedge clk);
		cfg_index <= REG_T0;   cfg_data <= 16'(t0);   @(posedge clk);
		cfg_index <= REG_TOP;  cfg_data <= 16'(top);  @(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_runs(input int count, input logic last_part);
		int          sent;
		int          run;
		logic [3:0]  ch;
		logic [11:0] target;
		sent = 0;
		while (sent < count) begin
			if (last_part && sent > count - 100)
				steady = 1'b1;
			ch = $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(1));
			case ($urandom_range(3))
				0: target = 12'($urandom_range(4095));
				1: target = 12'($urandom_range(40));
				2: target = 12'($urandom_range(4095, 4050));
				default: target = 12'($urandom_range(3000, 1000));
			endcase
			run = $urandom_range(1, 30);
			for (int i = 0; i < run && sent < count; i++) begin
				if ($urandom_range(7) == 0)
					send_sample(ch, 12'($urandom));
				else
					send_sample(ch, target);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(4'd0, 12'd0);
		send_sample(4'd1, 12'd4095);
		for (int c = 2; c < 16; c++)
			send_sample(4'(c), 12'($urandom));
		send_sample(4'd0, 12'd2048);
		send_sample(4'd1, 12'd1);
		send_sample(4'd0, 12'hAAA);
		send_sample(4'd1, 12'h555);
		drain();

		write_settings(15'd1, 16'd65535, 16'd1, 8'h80, 1'b1);
		random_runs(150, 1'b0);
		drain();
		write_settings(15'd32767, 16'd1, 16'd65535, 8'h7F, 1'b0);
		random_runs(150, 1'b0);
		drain();
		write_settings(15'd0, 16'd0, 16'd0, 8'h00, 1'b1);
		random_runs(100, 1'b0);
		drain();
		for (int p = 0; p < 2; p++) begin
			write_settings(15'($urandom_range(1, 32767)), 16'($urandom_range(1, 65535)),
				16'($urandom_range(1, 65535)), 8'($urandom), 1'($urandom));
			random_runs(120, 1'b0);
			drain();
		end
		write_settings(15'd3380, 16'd10000, 16'd10000, 8'd25, 1'b0);
		random_runs(180, 1'b1);
		drain();
		repeat (300) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(12 * 4000000);
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ ntc_thermistor_temperature_unit.f @@
sv/ntc_pkg.sv
sv/ntc_ctrl.sv
sv/ntc_dp.sv
sv/ntc_thermistor_temperature_unit.sv
bench/ntc_temperature_checker.sv
bench/tb_ntc_thermistor_temperature_unit.sv
